// File: design/pwcr_pkg.sv
// shared types and constants for the pulse width capture ring
`default_nettype none

package pwcr_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_RING_DEPTH    = 10;
    localparam int DEF_OVERFLOW_BITS = 16;

    // field widths fixed by the stream format
    localparam int COUNT_W = 16;
    localparam int WIDTH_W = 32;
    localparam int SLOT_W  = 4;

    // period register value after reset
    localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'hffff;

    // event kind codes on the input tuser
    localparam logic KIND_OVERFLOW = 1'b0;
    localparam logic KIND_CAPTURE  = 1'b1;

    // one input beat
    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] capture_value;
    } in_item_t;

    // one result beat
    typedef struct packed {
        logic               arm_falling;
        logic               width_valid;
        logic [WIDTH_W-1:0] pulse_width;
        logic [SLOT_W-1:0]  slot_written;
    } result_t;

endpackage

`default_nettype wire

// File: design/pwcr_in_reg.sv
// input register stage of the pulse width capture ring
`default_nettype none

module pwcr_in_reg
    import pwcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_valid,
    input  wire in_item_t s_item,
    output logic          s_ready,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // accept when empty or when the held beat moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: design/pwcr_ring.sv
// storage ring of recent pulse widths
`default_nettype none

module pwcr_ring
    import pwcr_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [WIDTH_W-1:0] wr_data
);

    logic [WIDTH_W-1:0] ring_mem [RING_DEPTH];

    // one write port, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/pwcr_meas.sv
// measurement state, width arithmetic and result formation
`default_nettype none

module pwcr_meas
    import pwcr_pkg::*;
#(
    parameter int RING_DEPTH    = DEF_RING_DEPTH,
    parameter int OVERFLOW_BITS = DEF_OVERFLOW_BITS,
    parameter int ADDR_W        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    input  wire logic               advance,
    input  wire in_item_t           item,
    output result_t                 result,
    output logic                    ring_wr_en,
    output logic [ADDR_W-1:0]       ring_wr_addr,
    output logic [WIDTH_W-1:0]      ring_wr_data
);

    localparam int PROD_W = COUNT_W + OVERFLOW_BITS;
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = '1;
    localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(RING_DEPTH - 1);

    logic [COUNT_W-1:0]       period_reg;
    logic                     awaiting_fall_reg;
    logic                     awaiting_fall_next;
    logic [COUNT_W-1:0]       start_reg;
    logic [COUNT_W-1:0]       start_next;
    logic [OVERFLOW_BITS-1:0] ovf_reg;
    logic [OVERFLOW_BITS-1:0] ovf_next;
    logic [ADDR_W-1:0]        slot_reg;
    logic [ADDR_W-1:0]        slot_next;

    logic                     is_fall;
    logic                     end_below;
    logic [OVERFLOW_BITS-1:0] wrap_mult;
    logic [PROD_W-1:0]        product;
    logic [PROD_W+WIDTH_W-1:0] product_ext;
    logic [WIDTH_W-1:0]       diff;
    logic [WIDTH_W-1:0]       width;
    logic [ADDR_W+SLOT_W-1:0] slot_ext;

    assign is_fall = (item.kind == KIND_CAPTURE) && awaiting_fall_reg;

    // width = (end - start) + period * m, m bumped to one when the end wrapped
    // with no overflow seen; equal start and end give zero
    assign end_below   = item.capture_value < start_reg;
    assign wrap_mult   = (end_below && (ovf_reg == '0)) ?
                         OVERFLOW_BITS'(1) : ovf_reg;
    assign product     = PROD_W'(period_reg) * PROD_W'(wrap_mult);
    assign product_ext = {{WIDTH_W{1'b0}}, product};
    assign diff        = WIDTH_W'(item.capture_value) - WIDTH_W'(start_reg);
    assign width       = (item.capture_value == start_reg) ? '0 :
                         diff + product_ext[WIDTH_W-1:0];

    // next state per event kind
    always_comb
    begin
        awaiting_fall_next = awaiting_fall_reg;
        start_next         = start_reg;
        ovf_next           = ovf_reg;
        slot_next          = slot_reg;
        unique case (item.kind)
            KIND_OVERFLOW:
            begin
                if (ovf_reg != OVF_MAX)
                begin
                    ovf_next = ovf_reg + OVERFLOW_BITS'(1);
                end
            end
            KIND_CAPTURE:
            begin
                if (!awaiting_fall_reg)
                begin
                    start_next         = item.capture_value;
                    ovf_next           = '0;
                    awaiting_fall_next = 1'b1;
                end
                else
                begin
                    awaiting_fall_next = 1'b0;
                    slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                awaiting_fall_next = awaiting_fall_reg;
            end
        endcase
    end

    // control state and period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg        <= PERIOD_RESET;
            awaiting_fall_reg <= 1'b0;
            start_reg         <= '0;
            ovf_reg           <= '0;
            slot_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                awaiting_fall_reg <= awaiting_fall_next;
                start_reg         <= start_next;
                ovf_reg           <= ovf_next;
                slot_reg          <= slot_next;
            end
        end
    end

    // result fields: width and slot are zero when no pulse completed
    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};

    always_comb
    begin
        result.arm_falling  = awaiting_fall_next;
        result.width_valid  = is_fall;
        result.pulse_width  = is_fall ? width : '0;
        result.slot_written = is_fall ? slot_ext[SLOT_W-1:0] : '0;
    end

    // ring write on a completed pulse
    assign ring_wr_en   = advance && is_fall;
    assign ring_wr_addr = slot_reg;
    assign ring_wr_data = width;

endmodule

`default_nettype wire

// File: design/pulse_width_capture_ring.sv
// top level of the pulse width capture ring
//
// channel   dir  tdata                                        tuser
// s_*       in   [15:0] capture_value                         kind
// m_*       out  [0] arm_falling, [32:1] pulse_width,         width_valid
//                [36:33] slot_written, [39:37] zero
// cfg_*     in   [15:0] counter_period on cfg_wr_en            -
//
// one beat per cycle sustained while the output is not stalled; an input beat passes
// through the input register, then the result register, one width multiply between them
// reset clears phase, start, overflow count and slot, and sets the period to 0xffff
// a stalled output holds its beat; the input register keeps taking beats until
// both stages are full
`default_nettype none

module pulse_width_capture_ring
    import pwcr_pkg::*;
#(
    parameter int RING_DEPTH    = DEF_RING_DEPTH,
    parameter int OVERFLOW_BITS = DEF_OVERFLOW_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,   // [15:0] capture_value
    input  wire logic               s_tuser,   // [0] kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [39:0]             m_tdata,   // arm_falling, pulse_width, slot_written
    output logic                    m_tuser,   // [0] width_valid
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    in_item_t           s_item;
    in_item_t           item;
    logic               item_valid;
    logic               advance;
    result_t            result;
    logic               ring_wr_en;
    logic [ADDR_W-1:0]  ring_wr_addr;
    logic [WIDTH_W-1:0] ring_wr_data;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;

    assign s_item.kind          = s_tuser;
    assign s_item.capture_value = s_tdata;

    // a held beat moves on when the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || m_tready);

    pwcr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_item     (s_item),
        .s_ready    (s_tready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pwcr_meas #(
        .RING_DEPTH    (RING_DEPTH),
        .OVERFLOW_BITS (OVERFLOW_BITS),
        .ADDR_W        (ADDR_W)
    ) u_meas (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .advance      (advance),
        .item         (item),
        .result       (result),
        .ring_wr_en   (ring_wr_en),
        .ring_wr_addr (ring_wr_addr),
        .ring_wr_data (ring_wr_data)
    );

    pwcr_ring #(
        .RING_DEPTH (RING_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // output beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.width_valid;
    assign m_tdata  = {3'b000, out_reg.slot_written, out_reg.pulse_width,
                       out_reg.arm_falling};

    // a completed pulse always rearms the rising edge
    a_fall_rearms_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[0])
        else $error("completed pulse did not rearm the rising edge");

    // width and slot stay zero on beats that complete no pulse
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[36:1] == 36'd0))
        else $error("width or slot set on a beat without a measurement");

    // slot stays inside the ring when the slot field can show all of it
    a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            ((RING_DEPTH > 16) || (int'(m_tdata[36:33]) < RING_DEPTH)))
        else $error("slot index beyond ring depth");

    // both stages full and output stalled closes the input
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while both stages were full");

endmodule

`default_nettype wire
